FILE: design/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
// No dependencies; used by i2cm_front, i2cm_engine and i2c_bit_level_master.
package i2cm_pkg;

    localparam int TICK_COUNT_WIDTH_DEF = 16;
    localparam int HALF_WIDTH           = 16;
    localparam logic [HALF_WIDTH-1:0] HALF_RESET = 16'd250;

    localparam int IN_DATA_WIDTH  = 16;
    localparam int OUT_DATA_WIDTH = 16;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam logic [CFG_AW-1:0] ADDR_HALF_PERIOD = 3'd0;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam logic [3:0] LAST_DATA_BIT = 4'd7;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic [3:0] BITS_PER_XFER = 4'd9;

    typedef enum logic [4:0] {
        KIND_NONE  = 5'b00001,
        KIND_START = 5'b00010,
        KIND_STOP  = 5'b00100,
        KIND_WRITE = 5'b01000,
        KIND_READ  = 5'b10000
    } t_kind;

    typedef enum logic [4:0] {
        MODE_IDLE  = 5'b00001,
        MODE_START = 5'b00010,
        MODE_STOP  = 5'b00100,
        MODE_WRITE = 5'b01000,
        MODE_READ  = 5'b10000
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] wbyte;
        logic       sda;
    } t_tick;

    typedef struct packed {
        logic  valid;
        t_tick tick;
    } t_queue_head;

endpackage

FILE: design/i2cm_front.sv
// Input side: accepts tick requests, decodes the command and queues them.
// Depends on i2cm_pkg.
module i2cm_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [i2cm_pkg::IN_DATA_WIDTH-1:0]   i_s_axis_tdata,
    input  logic                                 i_pop,
    output i2cm_pkg::t_queue_head                o_head
);

    logic [i2cm_pkg::QUEUE_AW:0]   r_count, n_count;
    logic [i2cm_pkg::QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    i2cm_pkg::t_tick               r_mem [i2cm_pkg::QUEUE_DEPTH];
    i2cm_pkg::t_tick               w_tick;
    logic                          w_push;
    logic                          w_pop;

    always_comb begin
        w_tick.wbyte = i_s_axis_tdata[10:3];
        w_tick.sda   = i_s_axis_tdata[11];
        if (!i_s_axis_tdata[0]) begin
            w_tick.kind = i2cm_pkg::KIND_NONE;
        end else begin
            case (i_s_axis_tdata[2:1])
                i2cm_pkg::OP_START: w_tick.kind = i2cm_pkg::KIND_START;
                i2cm_pkg::OP_STOP:  w_tick.kind = i2cm_pkg::KIND_STOP;
                i2cm_pkg::OP_WRITE: w_tick.kind = i2cm_pkg::KIND_WRITE;
                default:            w_tick.kind = i2cm_pkg::KIND_READ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_count != (i2cm_pkg::QUEUE_AW+1)'(i2cm_pkg::QUEUE_DEPTH));
    assign w_push = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_tick;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.tick  = r_mem[r_rd_ptr];

endmodule

FILE: design/i2cm_engine.sv
// Bus side: runs the start/stop/byte sequencer one queued tick at a time
// and holds each result in an output register. Depends on i2cm_pkg.
module i2cm_engine #(
    parameter int TICK_COUNT_WIDTH = i2cm_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [i2cm_pkg::HALF_WIDTH-1:0]      i_half_period,
    input  i2cm_pkg::t_queue_head                i_head,
    output logic                                 o_pop,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [i2cm_pkg::OUT_DATA_WIDTH-1:0]  o_m_axis_tdata
);

    localparam logic [32:0] CMASK = (33'd1 << TICK_COUNT_WIDTH) - 33'd1;

    i2cm_pkg::t_mode             r_mode, n_mode;
    logic                        r_phase, n_phase;
    logic [3:0]                  r_bit, n_bit;
    logic [7:0]                  r_shift, n_shift;
    logic [TICK_COUNT_WIDTH-1:0] r_ticks, n_ticks;
    logic                        r_scl, n_scl;
    logic                        r_sda, n_sda;
    logic [7:0]                  r_captured, n_captured;
    logic                        r_out_valid;
    logic [i2cm_pkg::OUT_DATA_WIDTH-1:0] r_out_data, n_out_data;
    logic [32:0]                 w_half_ext;
    logic [TICK_COUNT_WIDTH-1:0] w_limit_raw, w_limit;
    logic                        n_done;
    logic [3:0]                  w_bit_inc;

    assign w_half_ext  = 33'(i_half_period);
    assign w_limit_raw = (w_half_ext > CMASK) ? CMASK[TICK_COUNT_WIDTH-1:0]
                                              : w_half_ext[TICK_COUNT_WIDTH-1:0];
    assign w_limit     = (w_limit_raw == '0) ? TICK_COUNT_WIDTH'(1) : w_limit_raw;
    assign w_bit_inc   = r_bit + 4'd1;

    assign o_pop = i_head.valid && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_ticks    = r_ticks;
        n_scl      = r_scl;
        n_sda      = r_sda;
        n_captured = r_captured;
        n_done     = 1'b0;
        if (r_mode == i2cm_pkg::MODE_IDLE) begin
            if (i_head.tick.kind != i2cm_pkg::KIND_NONE) begin
                n_bit   = '0;
                n_phase = 1'b0;
                n_ticks = TICK_COUNT_WIDTH'(1);
                case (i_head.tick.kind)
                    i2cm_pkg::KIND_START: begin
                        n_mode = i2cm_pkg::MODE_START;
                        n_scl  = 1'b1;
                        n_sda  = 1'b1;
                    end
                    i2cm_pkg::KIND_STOP: begin
                        n_mode = i2cm_pkg::MODE_STOP;
                        n_scl  = 1'b1;
                        n_sda  = 1'b0;
                    end
                    i2cm_pkg::KIND_WRITE: begin
                        n_mode  = i2cm_pkg::MODE_WRITE;
                        n_shift = i_head.tick.wbyte;
                        n_scl   = 1'b0;
                        n_sda   = |(i_head.tick.wbyte & i2cm_pkg::MSB_MASK);
                    end
                    default: begin
                        n_mode  = i2cm_pkg::MODE_READ;
                        n_shift = '0;
                        n_scl   = 1'b0;
                        n_sda   = 1'b1;
                    end
                endcase
            end
        end else if (r_ticks < w_limit) begin
            n_ticks = r_ticks + 1'b1;
        end else if (r_mode == i2cm_pkg::MODE_START || r_mode == i2cm_pkg::MODE_STOP) begin
            if (!r_phase) begin
                n_phase = 1'b1;
                n_scl   = 1'b1;
                n_sda   = (r_mode == i2cm_pkg::MODE_STOP);
                n_ticks = TICK_COUNT_WIDTH'(1);
            end else begin
                if (r_mode == i2cm_pkg::MODE_START) begin
                    n_scl = 1'b0;
                end
                n_done = 1'b1;
            end
        end else if (!r_phase) begin
            n_phase = 1'b1;
            n_scl   = 1'b1;
            n_ticks = TICK_COUNT_WIDTH'(1);
        end else begin
            if (r_mode == i2cm_pkg::MODE_WRITE) begin
                n_shift = {r_shift[6:0], 1'b0};
            end else if (r_bit < i2cm_pkg::BITS_PER_BYTE) begin
                n_shift = {r_shift[6:0], i_head.tick.sda};
                if (r_bit == i2cm_pkg::LAST_DATA_BIT) begin
                    n_captured = n_shift;
                end
            end
            n_bit = w_bit_inc;
            if (w_bit_inc >= i2cm_pkg::BITS_PER_XFER) begin
                n_scl  = 1'b0;
                n_sda  = 1'b1;
                n_done = 1'b1;
            end else begin
                n_phase = 1'b0;
                n_scl   = 1'b0;
                n_ticks = TICK_COUNT_WIDTH'(1);
                if (r_mode == i2cm_pkg::MODE_WRITE && w_bit_inc < i2cm_pkg::BITS_PER_BYTE) begin
                    n_sda = n_shift[7];
                end else begin
                    n_sda = 1'b1;
                end
            end
        end
        if (n_done) begin
            n_mode  = i2cm_pkg::MODE_IDLE;
            n_phase = 1'b0;
            n_bit   = '0;
            n_ticks = '0;
        end
        n_out_data = {4'b0000, n_captured, n_done,
                      (n_mode != i2cm_pkg::MODE_IDLE), n_sda, n_scl};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= i2cm_pkg::MODE_IDLE;
            r_phase     <= 1'b0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_ticks     <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_captured  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode     <= n_mode;
                r_phase    <= n_phase;
                r_bit      <= n_bit;
                r_shift    <= n_shift;
                r_ticks    <= n_ticks;
                r_scl      <= n_scl;
                r_sda      <= n_sda;
                r_captured <= n_captured;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

FILE: design/i2c_bit_level_master.sv
// Top level of the I2C master byte engine: register port, input queue and
// bus sequencer. Depends on i2cm_pkg, i2cm_front and i2cm_engine.
//
// Channel   Direction  Request
// s_axis    in         one tick: command, write byte, sampled SDA
// m_axis    out        one result per tick: SCL, SDA, busy, done, read byte
// apb       in         register write/read (half_period_ticks at 0x0)
//
// One tick is taken per clock cycle while s_axis_tready is high. A tick is first
// written into the two-entry queue, then popped into the output register, from
// which its result is shown on m_axis.
// The sequencer advances only when the output register is free, so a stall
// on m_axis fills the queue and then drops s_axis_tready.
// Reset is synchronous and leaves the lines released with the engine idle.
module i2c_bit_level_master #(
    parameter int TICK_COUNT_WIDTH = i2cm_pkg::TICK_COUNT_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // cmd_valid[0], opcode[2:1], write_byte[10:3], sda_sample[11], zero[15:12]
    input  logic [i2cm_pkg::IN_DATA_WIDTH-1:0]   i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], read_byte[11:4], zero[15:12]
    output logic [i2cm_pkg::OUT_DATA_WIDTH-1:0]  o_m_axis_tdata,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [i2cm_pkg::CFG_AW-1:0]          paddr,
    input  logic [i2cm_pkg::CFG_DW-1:0]          pwdata,
    output logic [i2cm_pkg::CFG_DW-1:0]          prdata,
    output logic                                 pready
);

    logic [i2cm_pkg::HALF_WIDTH-1:0] r_half_period;
    i2cm_pkg::t_queue_head           w_head;
    logic                            w_pop;
    logic                            w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr == i2cm_pkg::ADDR_HALF_PERIOD) ? i2cm_pkg::CFG_DW'(r_half_period)
                                                            : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cm_pkg::HALF_RESET;
        end else if (w_cfg_wr && paddr == i2cm_pkg::ADDR_HALF_PERIOD) begin
            r_half_period <= pwdata[i2cm_pkg::HALF_WIDTH-1:0];
        end
    end

    i2cm_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_pop           (w_pop),
        .o_head          (w_head)
    );

    i2cm_engine #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_half_period   (r_half_period),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

`ifndef ASSERT_OFF
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |-> !o_m_axis_tdata[2])
        else $error("done reported while still busy");

    a_pop_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> o_m_axis_tvalid)
        else $error("queued tick produced no result");

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("sequencer advanced on an empty queue");
`endif

endmodule
